// File: rtl/core/bounded_kalman_1d_unit_defines.svh
// assertion macros for the bounded kalman 1d unit
// used by the checker module, needs clk and rst_n in scope
`ifndef BOUNDED_KALMAN_1D_UNIT_DEFINES_SVH
`define BOUNDED_KALMAN_1D_UNIT_DEFINES_SVH

// same-cycle implication
`define BK1D_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bk1d assertion failed");

// next-cycle implication
`define BK1D_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bk1d assertion failed");

`endif

// File: rtl/core/bk1d_pkg.sv
// shared types, constants and microprogram for the bounded kalman 1d unit
// no dependencies
`timescale 1ns / 1ps

package bk1d_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int CFG_IDX_W      = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_A_COEF          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_H_COEF          = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Q_VAR           = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_R_VAR           = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FC_LOW          = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FC_HIGH         = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_ESTIMATE   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_COVARIANCE = 3'd7;

    localparam int PROG_LEN = 42;
    localparam int PC_W     = $clog2(PROG_LEN);

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_SQRT,
        OP_MAX1,
        OP_WCLAMP,
        OP_KCLAMP
    } op_t;

    typedef enum logic [4:0] {
        S_Z, S_TS, S_X, S_P, S_AK, S_QK, S_RK, S_TPTS, S_KMIN, S_KMAX,
        S_HA, S_WLO, S_WHI, S_T1, S_T2, S_DZ, S_C, S_K, S_SQ, S_NORM, S_PF,
        S_ONE, S_TWOPI, S_A, S_H, S_Q, S_R, S_FL, S_FH
    } sel_t;

    typedef enum logic {
        MODE_DIV,
        MODE_SQRT
    } iter_mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        op_t  op;
        sel_t dst;
        sel_t srca;
        sel_t srcb;
    } uop_t;

    typedef struct packed {
        logic start;
        logic load_in;
        logic load_out;
        uop_t uop;
    } cmd_t;

    typedef struct packed {
        logic done;
    } status_t;

    function automatic logic [63:0] one_q(input int w, input int f);
        logic [63:0] mx;
        mx = (64'd1 << (w - 1)) - 64'd1;
        if (f >= w - 1)
            return mx;
        return 64'd1 << f;
    endfunction

    function automatic logic [63:0] two_pi_q(input int w, input int f);
        logic [63:0] c;
        logic [63:0] mx;
        mx = (64'd1 << (w - 1)) - 64'd1;
        c  = 64'd26986075409;
        if (f < 32)
            c = (c + (64'd1 << (31 - f))) >> (32 - f);
        if (c > mx)
            c = mx;
        return c;
    endfunction

    function automatic uop_t prog_rom(input logic [PC_W-1:0] pc);
        uop_t u;
        case (pc)
            6'd0:    u = '{OP_MAX1,   S_TS,   S_TS,    S_TS};
            6'd1:    u = '{OP_MUL,    S_T1,   S_A,     S_TS};
            6'd2:    u = '{OP_ADD,    S_AK,   S_ONE,   S_T1};
            6'd3:    u = '{OP_MUL,    S_QK,   S_Q,     S_TS};
            6'd4:    u = '{OP_DIV,    S_RK,   S_R,     S_TS};
            6'd5:    u = '{OP_MUL,    S_TPTS, S_TWOPI, S_TS};
            6'd6:    u = '{OP_MUL,    S_KMIN, S_TPTS,  S_FL};
            6'd7:    u = '{OP_MUL,    S_KMAX, S_TPTS,  S_FH};
            6'd8:    u = '{OP_MUL,    S_HA,   S_H,     S_AK};
            6'd9:    u = '{OP_SUB,    S_T1,   S_AK,    S_ONE};
            6'd10:   u = '{OP_DIV,    S_WLO,  S_T1,    S_HA};
            6'd11:   u = '{OP_ADD,    S_T1,   S_AK,    S_ONE};
            6'd12:   u = '{OP_DIV,    S_WHI,  S_T1,    S_HA};
            6'd13:   u = '{OP_WCLAMP, S_KMIN, S_KMIN,  S_KMIN};
            6'd14:   u = '{OP_WCLAMP, S_KMAX, S_KMAX,  S_KMAX};
            6'd15:   u = '{OP_MAX1,   S_P,    S_P,     S_P};
            6'd16:   u = '{OP_MUL,    S_X,    S_X,     S_AK};
            6'd17:   u = '{OP_MUL,    S_T1,   S_AK,    S_P};
            6'd18:   u = '{OP_MUL,    S_T1,   S_T1,    S_AK};
            6'd19:   u = '{OP_ADD,    S_P,    S_T1,    S_QK};
            6'd20:   u = '{OP_MUL,    S_T1,   S_H,     S_X};
            6'd21:   u = '{OP_SUB,    S_DZ,   S_Z,     S_T1};
            6'd22:   u = '{OP_MUL,    S_T1,   S_H,     S_P};
            6'd23:   u = '{OP_MUL,    S_T1,   S_T1,    S_H};
            6'd24:   u = '{OP_ADD,    S_C,    S_T1,    S_RK};
            6'd25:   u = '{OP_MAX1,   S_C,    S_C,     S_C};
            6'd26:   u = '{OP_MUL,    S_T1,   S_P,     S_H};
            6'd27:   u = '{OP_DIV,    S_T1,   S_T1,    S_C};
            6'd28:   u = '{OP_KCLAMP, S_K,    S_T1,    S_T1};
            6'd29:   u = '{OP_MUL,    S_T1,   S_K,     S_DZ};
            6'd30:   u = '{OP_ADD,    S_X,    S_X,     S_T1};
            6'd31:   u = '{OP_MUL,    S_T1,   S_K,     S_H};
            6'd32:   u = '{OP_SUB,    S_T2,   S_ONE,   S_T1};
            6'd33:   u = '{OP_MUL,    S_T1,   S_T2,    S_P};
            6'd34:   u = '{OP_MUL,    S_T1,   S_T1,    S_T2};
            6'd35:   u = '{OP_MUL,    S_T2,   S_K,     S_RK};
            6'd36:   u = '{OP_MUL,    S_T2,   S_T2,    S_K};
            6'd37:   u = '{OP_ADD,    S_P,    S_T1,    S_T2};
            6'd38:   u = '{OP_SQRT,   S_SQ,   S_C,     S_C};
            6'd39:   u = '{OP_MAX1,   S_SQ,   S_SQ,    S_SQ};
            6'd40:   u = '{OP_DIV,    S_NORM, S_DZ,    S_SQ};
            6'd41:   u = '{OP_DIV,    S_PF,   S_K,     S_TPTS};
            default: u = '{OP_MAX1,   S_T1,   S_T1,    S_T1};
        endcase
        return u;
    endfunction

endpackage

// File: rtl/core/bk1d_iter.sv
// shared radix-2 divide and square root unit, one quotient or root bit per cycle
// depends on bk1d_pkg
`timescale 1ns / 1ps

module bk1d_iter
    import bk1d_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  iter_mode_t            mode,
    input  logic [DATA_WIDTH-1:0] a,
    input  logic [DATA_WIDTH-1:0] b,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] result
);

    localparam int W   = DATA_WIDTH;
    localparam int NW  = W + FRAC_BITS;
    localparam int SB  = (NW + 1) / 2;
    localparam int RW  = 2 * SB;
    localparam int RMW = (W + 1 > SB + 2) ? W + 1 : SB + 2;
    localparam int CW  = $clog2(NW + 1);
    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    logic             busy_reg;
    logic             busy_next;
    logic [CW-1:0]    cnt_reg;
    iter_mode_t       mode_reg;
    logic             neg_reg;
    logic             zero_reg;
    logic             az_reg;
    logic [RW-1:0]    n_reg;
    logic [NW-1:0]    q_reg;
    logic [RMW-1:0]   rem_reg;
    logic [W-1:0]     d_reg;

    logic [W-1:0]     mag_a;
    logic [W-1:0]     mag_b;
    logic [RMW-1:0]   rem_sh;
    logic [RMW-1:0]   trial;
    logic             take;
    logic             rnd;
    logic [NW:0]      qr;
    logic             over;

    assign mag_a = a[W-1] ? (~a + 1'b1) : a;
    assign mag_b = b[W-1] ? (~b + 1'b1) : b;

    always_comb
    begin
        if (mode_reg == MODE_DIV)
        begin
            rem_sh = {rem_reg[RMW-2:0], n_reg[NW-1]};
            trial  = RMW'(d_reg);
        end
        else
        begin
            rem_sh = {rem_reg[RMW-3:0], n_reg[RW-1:RW-2]};
            trial  = RMW'({q_reg[SB-1:0], 2'b01});
        end
        take = (rem_sh >= trial);
    end

    assign done = busy_reg && (cnt_reg == '0);
    assign busy_next = start ? 1'b1 : (done ? 1'b0 : busy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (start)
                cnt_reg <= (mode == MODE_DIV) ? CW'(NW) : CW'(SB);
            else if (busy_reg && cnt_reg != '0)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mode_reg <= mode;
            rem_reg  <= '0;
            q_reg    <= '0;
            d_reg    <= mag_b;
            az_reg   <= (a == '0);
            if (mode == MODE_DIV)
            begin
                neg_reg  <= a[W-1] ^ b[W-1];
                zero_reg <= (b == '0);
                n_reg    <= RW'(mag_a) << FRAC_BITS;
            end
            else
            begin
                neg_reg  <= 1'b0;
                zero_reg <= a[W-1] || (a == '0);
                n_reg    <= RW'(a) << FRAC_BITS;
            end
        end
        else if (busy_reg && cnt_reg != '0)
        begin
            rem_reg <= take ? (rem_sh - trial) : rem_sh;
            q_reg   <= {q_reg[NW-2:0], take};
            n_reg   <= (mode_reg == MODE_DIV) ? (n_reg << 1) : (n_reg << 2);
        end
    end

    always_comb
    begin
        rnd  = (mode_reg == MODE_DIV) && ({rem_reg, 1'b0} >= (RMW+1)'(d_reg));
        qr   = (NW+1)'(q_reg) + (NW+1)'(rnd);
        over = qr > (NW+1)'(MAXV);
        if (mode_reg == MODE_DIV && zero_reg)
            result = az_reg ? '0 : (neg_reg ? MINV : MAXV);
        else if (mode_reg == MODE_SQRT && zero_reg)
            result = '0;
        else if (over)
            result = neg_reg ? MINV : MAXV;
        else
            result = neg_reg ? (~qr[W-1:0] + 1'b1) : qr[W-1:0];
    end

endmodule

// File: rtl/core/bk1d_datapath.sv
// datapath: working registers, configuration registers, saturating alu,
// registered multiplier and the shared divide/root unit
// depends on bk1d_pkg and bk1d_iter
`timescale 1ns / 1ps

module bk1d_datapath
    import bk1d_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output status_t               status,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [DATA_WIDTH-1:0] cfg_data,
    input  logic [DATA_WIDTH-1:0] measurement,
    input  logic [DATA_WIDTH-2:0] sample_time,
    output logic [DATA_WIDTH-1:0] estimate,
    output logic [DATA_WIDTH-1:0] innovation_norm,
    output logic [DATA_WIDTH-1:0] pole_freq
);

    localparam int W = DATA_WIDTH;
    localparam logic [W-1:0] MAXV    = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV    = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] ONE_V   = W'(one_q(DATA_WIDTH, FRAC_BITS));
    localparam logic [W-1:0] TWOPI_V = W'(two_pi_q(DATA_WIDTH, FRAC_BITS));

    logic [W-1:0] a_reg, h_reg, q_reg, r_reg, fl_reg, fh_reg;
    logic [W-1:0] x_reg, p_reg;
    logic [W-1:0] z_reg, ts_reg, ak_reg, qk_reg, rk_reg, tpts_reg, kmin_reg, kmax_reg;
    logic [W-1:0] ha_reg, wlo_reg, whi_reg, t1_reg, t2_reg, dz_reg, c_reg, k_reg;
    logic [W-1:0] sq_reg, norm_reg, pf_reg;
    logic [W-1:0] est_out_reg, norm_out_reg, pf_out_reg;

    logic [W-1:0]   opa, opb;
    logic [W-1:0]   alu_res;
    logic           is_alu, is_iter, alu_start;
    logic [W:0]     sum;
    logic [W-1:0]   lo, hi;

    logic [2*W-1:0] prod_reg;
    logic           mneg_reg;
    logic           mul_pend_reg;
    logic [2*W:0]   mrnd;
    logic [2*W:0]   mshift;
    logic [W-1:0]   mul_res;
    logic [W-1:0]   ma, mb;

    logic           iter_done;
    logic [W-1:0]   iter_res;
    sel_t           dst_reg;
    sel_t           wr_dst;
    logic           wr_en;
    logic [W-1:0]   wr_data;
    logic           done_reg;

    function automatic logic [W-1:0] pick(input sel_t s);
        logic [W-1:0] v;
        case (s)
            S_Z:     v = z_reg;
            S_TS:    v = ts_reg;
            S_X:     v = x_reg;
            S_P:     v = p_reg;
            S_AK:    v = ak_reg;
            S_QK:    v = qk_reg;
            S_RK:    v = rk_reg;
            S_TPTS:  v = tpts_reg;
            S_KMIN:  v = kmin_reg;
            S_KMAX:  v = kmax_reg;
            S_HA:    v = ha_reg;
            S_WLO:   v = wlo_reg;
            S_WHI:   v = whi_reg;
            S_T1:    v = t1_reg;
            S_T2:    v = t2_reg;
            S_DZ:    v = dz_reg;
            S_C:     v = c_reg;
            S_K:     v = k_reg;
            S_SQ:    v = sq_reg;
            S_NORM:  v = norm_reg;
            S_PF:    v = pf_reg;
            S_ONE:   v = ONE_V;
            S_TWOPI: v = TWOPI_V;
            S_A:     v = a_reg;
            S_H:     v = h_reg;
            S_Q:     v = q_reg;
            S_R:     v = r_reg;
            S_FL:    v = fl_reg;
            S_FH:    v = fh_reg;
            default: v = '0;
        endcase
        return v;
    endfunction

    assign opa = pick(cmd.uop.srca);
    assign opb = pick(cmd.uop.srcb);

    assign is_alu    = cmd.uop.op inside {OP_ADD, OP_SUB, OP_MAX1, OP_WCLAMP, OP_KCLAMP};
    assign is_iter   = cmd.uop.op inside {OP_DIV, OP_SQRT};
    assign alu_start = cmd.start && is_alu;

    // saturating alu
    always_comb
    begin
        sum = '0;
        lo  = '0;
        hi  = '0;
        case (cmd.uop.op)
            OP_ADD, OP_SUB:
            begin
                if (cmd.uop.op == OP_ADD)
                    sum = {opa[W-1], opa} + {opb[W-1], opb};
                else
                    sum = {opa[W-1], opa} - {opb[W-1], opb};
                if (sum[W] != sum[W-1])
                    alu_res = sum[W] ? MINV : MAXV;
                else
                    alu_res = sum[W-1:0];
            end
            OP_MAX1:
                alu_res = ($signed(opa) < $signed(W'(1))) ? W'(1) : opa;
            OP_WCLAMP:
            begin
                lo = ha_reg[W-1] ? whi_reg : wlo_reg;
                hi = ha_reg[W-1] ? wlo_reg : whi_reg;
                if (ha_reg == '0)
                    alu_res = opa;
                else if ($signed(opa) < $signed(lo))
                    alu_res = lo;
                else if ($signed(opa) > $signed(hi))
                    alu_res = hi;
                else
                    alu_res = opa;
            end
            OP_KCLAMP:
            begin
                if ($signed(opa) < $signed(kmin_reg))
                    alu_res = kmin_reg;
                else if ($signed(opa) > $signed(kmax_reg))
                    alu_res = kmax_reg;
                else
                    alu_res = opa;
            end
            default:
                alu_res = opa;
        endcase
    end

    // multiplier, product registered then rounded and saturated
    assign ma = opa[W-1] ? (~opa + 1'b1) : opa;
    assign mb = opb[W-1] ? (~opb + 1'b1) : opb;

    always_ff @(posedge clk)
    begin
        if (cmd.start && cmd.uop.op == OP_MUL)
        begin
            prod_reg <= (2*W)'(ma) * (2*W)'(mb);
            mneg_reg <= opa[W-1] ^ opb[W-1];
        end
    end

    always_comb
    begin
        mrnd   = (2*W+1)'(prod_reg) + ((2*W+1)'(1) << (FRAC_BITS - 1));
        mshift = mrnd >> FRAC_BITS;
        if (mshift > (2*W+1)'(MAXV))
            mul_res = mneg_reg ? MINV : MAXV;
        else
            mul_res = mneg_reg ? (~mshift[W-1:0] + 1'b1) : mshift[W-1:0];
    end

    bk1d_iter #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_iter (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.start && is_iter),
        .mode   ((cmd.uop.op == OP_SQRT) ? MODE_SQRT : MODE_DIV),
        .a      (opa),
        .b      (opb),
        .done   (iter_done),
        .result (iter_res)
    );

    assign wr_en   = alu_start || mul_pend_reg || iter_done;
    assign wr_dst  = alu_start ? cmd.uop.dst : dst_reg;
    assign wr_data = iter_done ? iter_res : (mul_pend_reg ? mul_res : alu_res);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_pend_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            mul_pend_reg <= cmd.start && (cmd.uop.op == OP_MUL);
            done_reg     <= wr_en;
        end
    end

    assign status.done = done_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.start)
            dst_reg <= cmd.uop.dst;
    end

    // configuration registers and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg  <= '0;
            h_reg  <= ONE_V;
            q_reg  <= '0;
            r_reg  <= ONE_V;
            fl_reg <= '0;
            fh_reg <= ONE_V;
            x_reg  <= '0;
            p_reg  <= ONE_V;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_A_COEF:          a_reg  <= cfg_data;
                CFG_H_COEF:          h_reg  <= cfg_data;
                CFG_Q_VAR:           q_reg  <= {1'b0, cfg_data[W-2:0]};
                CFG_R_VAR:           r_reg  <= {1'b0, cfg_data[W-2:0]};
                CFG_FC_LOW:          fl_reg <= {1'b0, cfg_data[W-2:0]};
                CFG_FC_HIGH:         fh_reg <= {1'b0, cfg_data[W-2:0]};
                CFG_INIT_ESTIMATE:   x_reg  <= cfg_data;
                CFG_INIT_COVARIANCE: p_reg  <= {1'b0, cfg_data[W-2:0]};
                default:             ;
            endcase
        end
        else if (wr_en)
        begin
            case (wr_dst)
                S_X:     x_reg <= wr_data;
                S_P:     p_reg <= wr_data;
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            z_reg  <= measurement;
            ts_reg <= {1'b0, sample_time};
        end
        else if (wr_en)
        begin
            case (wr_dst)
                S_Z:     z_reg    <= wr_data;
                S_TS:    ts_reg   <= wr_data;
                S_AK:    ak_reg   <= wr_data;
                S_QK:    qk_reg   <= wr_data;
                S_RK:    rk_reg   <= wr_data;
                S_TPTS:  tpts_reg <= wr_data;
                S_KMIN:  kmin_reg <= wr_data;
                S_KMAX:  kmax_reg <= wr_data;
                S_HA:    ha_reg   <= wr_data;
                S_WLO:   wlo_reg  <= wr_data;
                S_WHI:   whi_reg  <= wr_data;
                S_T1:    t1_reg   <= wr_data;
                S_T2:    t2_reg   <= wr_data;
                S_DZ:    dz_reg   <= wr_data;
                S_C:     c_reg    <= wr_data;
                S_K:     k_reg    <= wr_data;
                S_SQ:    sq_reg   <= wr_data;
                S_NORM:  norm_reg <= wr_data;
                S_PF:    pf_reg   <= wr_data;
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            est_out_reg  <= x_reg;
            norm_out_reg <= norm_reg;
            pf_out_reg   <= pf_reg;
        end
    end

    assign estimate        = est_out_reg;
    assign innovation_norm = norm_out_reg;
    assign pole_freq       = pf_out_reg;

endmodule

// File: rtl/core/bk1d_ctrl.sv
// controller: sequences the microprogram and runs the item handshakes
// depends on bk1d_pkg
`timescale 1ns / 1ps

module bk1d_ctrl
    import bk1d_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output cmd_t    cmd,
    input  status_t status
);

    localparam logic [PC_W-1:0] PC_LAST = PC_W'(PROG_LEN - 1);

    ctrl_state_t     state_reg, state_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    logic            out_valid_reg, out_valid_next;
    logic            accept;

    assign accept = in_valid && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept)
                    state_next = ST_ISSUE;
            ST_ISSUE:
                state_next = ST_WAIT;
            ST_WAIT:
                if (status.done)
                    state_next = (pc_reg == PC_LAST) ? ST_FINISH : ST_ISSUE;
            ST_FINISH:
                if (!out_valid_reg || out_ready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready     = (state_reg == ST_IDLE);
        cmd.load_in  = accept;
        cmd.start    = (state_reg == ST_ISSUE);
        cmd.load_out = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);
        cmd.uop      = prog_rom(pc_reg);
        out_valid    = out_valid_reg;
    end

    always_comb
    begin
        pc_next = pc_reg;
        if (accept)
            pc_next = '0;
        else if (state_reg == ST_WAIT && status.done && pc_reg != PC_LAST)
            pc_next = pc_reg + 1'b1;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: rtl/core/bounded_kalman_1d_unit.sv
// top level of the bounded-gain scalar kalman filter
// depends on bk1d_pkg, bk1d_ctrl and bk1d_datapath
//
//  channel | signals                                   | accepted when
//  in      | in_valid in_ready measurement sample_time | in_valid & in_ready
//  out     | out_valid out_ready estimate              | out_valid & out_ready
//          |   innovation_norm pole_freq               |
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data    | cfg_valid & cfg_ready
//
// one item at a time
// the microprogram runs six divides and one square root on the shared divide/root unit,
// and its other steps are alu steps and multiplies
// reset loads the default registers, estimate 0 and covariance 1.0
// a result waiting on out_ready does not block the next item from entering
`timescale 1ns / 1ps

module bounded_kalman_1d_unit
    import bk1d_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [DATA_WIDTH-1:0] measurement,
    input  logic [DATA_WIDTH-2:0] sample_time,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DATA_WIDTH-1:0] estimate,
    output logic [DATA_WIDTH-1:0] innovation_norm,
    output logic [DATA_WIDTH-1:0] pole_freq,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [DATA_WIDTH-1:0] cfg_data
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    bk1d_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    bk1d_datapath #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .measurement     (measurement),
        .sample_time     (sample_time),
        .estimate        (estimate),
        .innovation_norm (innovation_norm),
        .pole_freq       (pole_freq)
    );

endmodule

// File: rtl/core/bk1d_checker.sv
// port-level checker for bounded_kalman_1d_unit, with its bind
// depends on bounded_kalman_1d_unit_defines.svh
`timescale 1ns / 1ps
`include "bounded_kalman_1d_unit_defines.svh"

module bk1d_checker #(
    parameter int DATA_WIDTH = 32
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [DATA_WIDTH-1:0] estimate,
    input logic                  cfg_valid,
    input logic                  cfg_ready
);

    `BK1D_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    `BK1D_ASSERT_NOW(a_result_frees_input, $rose(out_valid), in_ready)
    `BK1D_ASSERT_NOW(a_cfg_always_ready, cfg_valid, cfg_ready)
    `BK1D_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid && $stable(estimate))

endmodule

bind bounded_kalman_1d_unit bk1d_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .estimate  (estimate),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

// File: verif/tb_bounded_kalman_1d_unit.sv
// self-checking testbench for bounded_kalman_1d_unit, the bounded-gain scalar kalman filter
// drives items, config writes and output stalls, and checks each result against its own
// q16.16 filter model; depends on bk1d_pkg and the unit rtl
`timescale 1ns / 1ps

module tb_bounded_kalman_1d_unit;
    import bk1d_pkg::*;

    localparam int  DW        = 32;
    localparam int  FB        = 16;
    localparam longint MAXV   = 64'sd2147483647;
    localparam longint MINV   = -64'sd2147483648;
    localparam longint ONE_Q  = 64'sd65536;
    localparam longint TWO_PI = (64'sd26986075409 + 64'sd32768) >>> 16;
    localparam int  N_PHASES  = 6;
    localparam int  PHASE_ITEMS = 300;

    typedef struct packed {
        logic [DW-1:0] est;
        logic [DW-1:0] innov;
        logic [DW-1:0] pole;
    } result_t;

    typedef struct {
        logic [DW-1:0] z;
        logic [DW-2:0] ts;
        bit            zero_typed;
    } row_t;

    logic            clk;
    logic            rst_n;
    logic            in_valid;
    logic            in_ready;
    logic [DW-1:0]   measurement;
    logic [DW-2:0]   sample_time;
    logic            out_valid;
    logic            out_ready;
    logic [DW-1:0]   estimate;
    logic [DW-1:0]   innovation_norm;
    logic [DW-1:0]   pole_freq;
    logic            cfg_valid;
    logic            cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DW-1:0]   cfg_data;

    longint m_a, m_h, m_q, m_r, m_fl, m_fh, m_ie, m_ic, m_x, m_p;
    result_t pending_results[$];
    int      errors = 0;
    int      phase;
    int      burst_left;
    int      hold_cnt = 0;
    bit      hold_done = 1'b0;
    int      ready_mode = 0;
    int      mode_cnt = 0;

    bounded_kalman_1d_unit i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .measurement     (measurement),
        .sample_time     (sample_time),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .estimate        (estimate),
        .innovation_norm (innovation_norm),
        .pole_freq       (pole_freq),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic logic [63:0] mag(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint from_mag(input bit neg, input logic [63:0] m);
        if (m > 64'(MAXV))
            return neg ? MINV : MAXV;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint sat(input longint v);
        if (v > MAXV)
            return MAXV;
        if (v < MINV)
            return MINV;
        return v;
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        logic [63:0] m;
        m = (mag(a) * mag(b) + 64'd32768) >> FB;
        return from_mag((a < 0) != (b < 0), m);
    endfunction

    function automatic longint qdiv(input longint a, input longint b);
        logic [63:0] n;
        logic [63:0] d;
        logic [63:0] q;
        logic [63:0] r;
        if (b == 0)
            return (a == 0) ? 0 : ((a < 0) ? MINV : MAXV);
        n = mag(a) << FB;
        d = mag(b);
        q = n / d;
        r = n % d;
        if (r >= d - r)
            q = q + 1;
        return from_mag((a < 0) != (b < 0), q);
    endfunction

    function automatic longint qsqrt(input longint a);
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] c;
        if (a <= 0)
            return 0;
        n = 64'(a) << FB;
        r = 0;
        for (int i = 31; i >= 0; i--)
        begin
            c = r | (64'd1 << i);
            if (c * c <= n)
                r = c;
        end
        return longint'(r);
    endfunction

    function automatic longint clampk(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [DW-1:0] d);
        longint s;
        longint u;
        s = longint'($signed(d));
        u = longint'(d[DW-2:0]);
        case (idx)
            CFG_A_COEF:          m_a = s;
            CFG_H_COEF:          m_h = s;
            CFG_Q_VAR:           m_q = u;
            CFG_R_VAR:           m_r = u;
            CFG_FC_LOW:          m_fl = u;
            CFG_FC_HIGH:         m_fh = u;
            CFG_INIT_ESTIMATE:   begin m_ie = s; m_x = s; end
            CFG_INIT_COVARIANCE: begin m_ic = u; m_p = u; end
            default: ;
        endcase
    endfunction

    function automatic result_t kalman_step(input logic [DW-1:0] zin, input logic [DW-2:0] tsin);
        longint z, ts, ak, qk, rk, tpts, kmin, kmax, ha, lo, hi, tmp;
        longint x, p, dz, c, k, t, sq;
        result_t res;
        z = longint'($signed(zin));
        ts = longint'(tsin);
        if (ts < 1)
            ts = 1;
        ak   = sat(ONE_Q + qmul(m_a, ts));
        qk   = qmul(m_q, ts);
        rk   = qdiv(m_r, ts);
        tpts = qmul(TWO_PI, ts);
        kmin = qmul(tpts, m_fl);
        kmax = qmul(tpts, m_fh);
        ha   = qmul(m_h, ak);
        if (ha != 0)
        begin
            lo = qdiv(sat(ak - ONE_Q), ha);
            hi = qdiv(sat(ak + ONE_Q), ha);
            if (ha < 0)
            begin
                tmp = lo;
                lo = hi;
                hi = tmp;
            end
            kmin = clampk(kmin, lo, hi);
            kmax = clampk(kmax, lo, hi);
        end
        p  = (m_p < 1) ? 1 : m_p;
        x  = qmul(m_x, ak);
        p  = sat(qmul(qmul(ak, p), ak) + qk);
        dz = sat(z - qmul(m_h, x));
        c  = sat(qmul(qmul(m_h, p), m_h) + rk);
        if (c < 1)
            c = 1;
        k  = clampk(qdiv(qmul(p, m_h), c), kmin, kmax);
        x  = sat(x + qmul(k, dz));
        t  = sat(ONE_Q - qmul(k, m_h));
        p  = sat(qmul(qmul(t, p), t) + qmul(qmul(k, rk), k));
        m_x = x;
        m_p = p;
        sq = qsqrt(c);
        if (sq < 1)
            sq = 1;
        res.est   = x[DW-1:0];
        res.innov = DW'(qdiv(dz, sq));
        res.pole  = DW'(qdiv(k, tpts));
        return res;
    endfunction

    task automatic send_item(input logic [DW-1:0] z, input logic [DW-2:0] ts, input bit zero_typed);
        result_t r;
        in_valid    <= 1'b1;
        measurement <= z;
        sample_time <= ts;
        do
            @(posedge clk);
        while (!in_ready);
        r = kalman_step(z, ts);
        if (zero_typed)
        begin
            r.est   = '0;
            r.innov = '0;
        end
        pending_results.push_back(r);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 20);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic write_regs(input logic [DW-1:0] vals[8]);
        for (int i = 0; i < 8; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            apply_cfg(CFG_IDX_W'(i), vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [DW-2:0] rand_ts();
        int sel;
        sel = $urandom_range(0, 15);
        if (sel < 2)
            return (DW-1)'($urandom >> 1);
        if (sel == 2)
            return (DW-1)'($urandom_range(0, 1));
        return (DW-1)'($urandom_range(64, 6554));
    endfunction

    function automatic logic [DW-1:0] rand_z();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return DW'(m_x + longint'($urandom_range(0, 20 * 65536)) - 10 * 65536);
    endfunction

    // receiver stall pattern, with one long hold-off in phase 1
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_cnt > 0)
        begin
            hold_cnt  <= hold_cnt - 1;
            out_ready <= 1'b0;
        end
        else if (!hold_done && phase == 1)
        begin
            hold_done <= 1'b1;
            hold_cnt  <= 3000;
            out_ready <= 1'b0;
        end
        else
        begin
            if (mode_cnt == 0)
            begin
                mode_cnt   <= $urandom_range(50, 400);
                ready_mode <= $urandom_range(0, 2);
            end
            else
                mode_cnt <= mode_cnt - 1;
            case (ready_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= $urandom_range(0, 1);
                default: out_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        result_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected item: est %h innov %h pole %h",
                       estimate, innovation_norm, pole_freq);
                errors++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (estimate !== e.est)
                begin
                    $error("estimate: expected %h actual %h", e.est, estimate);
                    errors++;
                end
                if (innovation_norm !== e.innov)
                begin
                    $error("innovation_norm: expected %h actual %h", e.innov, innovation_norm);
                    errors++;
                end
                if (pole_freq !== e.pole)
                begin
                    $error("pole_freq: expected %h actual %h", e.pole, pole_freq);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("[bounded_kalman_1d_unit] ERROR");
        $finish;
    end

    initial
    begin
        row_t rows[$];
        logic [DW-1:0] regs[8];
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        measurement = '0;
        sample_time = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        phase = 0;
        burst_left = 0;
        m_a = 0; m_h = ONE_Q; m_q = 0; m_r = ONE_Q;
        m_fl = 0; m_fh = ONE_Q; m_ie = 0; m_ic = ONE_Q;
        m_x = 0; m_p = ONE_Q;

        // zero measurements from a zero state keep estimate and innovation at zero, then corner values follow
        rows = '{
            '{32'h0000_0000, 31'h0000_0000, 1'b1},
            '{32'h0000_0000, 31'h0000_0001, 1'b1},
            '{32'h0000_0000, 31'h0001_0000, 1'b1},
            '{32'h0000_0000, 31'h7fff_ffff, 1'b1},
            '{32'h0000_0000, 31'h0000_199a, 1'b1},
            '{32'h7fff_ffff, 31'h0000_199a, 1'b0},
            '{32'h8000_0000, 31'h0000_199a, 1'b0},
            '{32'h7fff_ffff, 31'h7fff_ffff, 1'b0},
            '{32'h8000_0000, 31'h0000_0000, 1'b0},
            '{32'h0001_0000, 31'h0001_0000, 1'b0},
            '{32'hffff_0000, 31'h0000_0001, 1'b0},
            '{32'h5555_5555, 31'h5555_5555, 1'b0},
            '{32'haaaa_aaaa, 31'h2aaa_aaaa, 1'b0},
            '{32'h0000_ffff, 31'h0000_0040, 1'b0}
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_item(rows[i].z, rows[i].ts, rows[i].zero_typed);
        drain_results();

        for (int ph = 1; ph < N_PHASES; ph++)
        begin
            case (ph)
                1: regs = '{32'hffff_8000, 32'h0001_0000, 32'h0000_199a, 32'h0000_8000,
                            32'h0000_199a, 32'h000a_0000, 32'h0064_0000, 32'h0001_0000};
                2: regs = '{32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 32'h7fff_ffff,
                            32'h0000_0000, 32'hffff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
                3: regs = '{32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000,
                            32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'h0000_0000};
                4: regs = '{32'h0001_0000, 32'hfffe_0000, 32'h0001_0000, 32'h0000_0001,
                            32'h0014_0000, 32'h0001_0000, 32'hfffb_0000, 32'h0000_0003};
                default:
                    regs = '{$urandom, 32'h0000_0000, $urandom, $urandom,
                             $urandom, $urandom, $urandom, $urandom};
            endcase
            write_regs(regs);
            phase = ph;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                send_item(rand_z(), rand_ts(), 1'b0);
                if (ph == 2 && n == PHASE_ITEMS / 2)
                    drain_results();
            end
            drain_results();
        end

        if (errors == 0)
            $display("[bounded_kalman_1d_unit] OK");
        else
            $display("[bounded_kalman_1d_unit] ERROR");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/bk1d_pkg.sv
rtl/core/bk1d_iter.sv
rtl/core/bk1d_datapath.sv
rtl/core/bk1d_ctrl.sv
rtl/core/bounded_kalman_1d_unit.sv
rtl/core/bk1d_checker.sv
verif/tb_bounded_kalman_1d_unit.sv
